// ===== design/lgge_pkg.sv =====
// Shared types and constants for the Life grid generation engine.
// No dependencies; used by lgge_row_rule and life_grid_generation_engine.
package lgge_pkg;

  // Command codes of an input word
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  // Configuration register indexes
  localparam logic [1:0] CfgColsIdx = 2'd0;
  localparam logic [1:0] CfgRowsIdx = 2'd1;

  localparam int                  DimRegW   = 7;
  localparam logic [DimRegW-1:0]  DimReset  = DimRegW'(64);

  // B3/S23 rule
  localparam logic [3:0] BirthCount   = 4'd3;
  localparam logic [3:0] SurviveCount = 4'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL,
    ST_STEP,
    ST_DONE
  } state_e;

endpackage

// ===== design/life_grid_generation_engine.sv =====
// Top level of the Life (B3/S23) grid generation engine with a dead border.
// Depends on lgge_pkg, lgge_grid_mem and lgge_row_rule.
//
//   channel | direction | handshake                 | word
//   --------+-----------+---------------------------+------------------------------------
//   in      | to block  | in_valid_i / in_stall_o   | cmd_i, row_i, col_i, cell_value_i
//   out     | from block| out_valid_o / out_stall_i | read_value_o, generation_count_o
//   cfg     | to block  | cfg_we_i                  | cfg_index_i, cfg_wdata_i
//
// Cell read and cell write words pass through accept, a memory read and the
// result stage; a no-op word goes from accept to the result stage. In a
// generation step the grid is swept one row per cycle through the single read
// port, plus fill and drain of the three-row window.
// After reset a clearing pass zeroes the live bank; no word is accepted
// during it (configuration writes are taken).
// The output register frees the input side: a new word is taken while a
// result still waits under out_stall_i.
module life_grid_generation_engine #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        cmd_i,
  input  logic signed [7:0] row_i,
  input  logic signed [7:0] col_i,
  input  logic              cell_value_i,
  // output channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              read_value_o,
  output logic [31:0]       generation_count_o,
  // configuration
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [6:0]        cfg_wdata_i
);

  // The grid lives as rows of MAX_COLS bits in two banks of one memory. A step
  // reads the live bank and writes the other, then flips bank_q, so no copy
  // pass is needed. The spare bank is always fully written before it is read.
  localparam int RowW = $clog2(MAX_ROWS);
  localparam int ColW = $clog2(MAX_COLS);
  localparam int AW   = RowW + 1;
  localparam int ScW  = $clog2(MAX_ROWS + 2);
  localparam int DimW = $clog2(((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS) + 2);
  localparam int CmpW = (DimW > 7) ? DimW : 7;

  lgge_pkg::state_e state_q, state_d;

  logic [6:0]          cols_q, rows_q;
  logic                bank_q, bank_d;
  logic [31:0]         gen_q, gen_d;
  logic [RowW-1:0]     clr_q, clr_d;
  logic [ScW-1:0]      sc_q, sc_d;
  logic [MAX_COLS-1:0] prev_q, cur_q;

  lgge_pkg::cmd_e      cmd_q;
  logic [6:0]          row_q, col_q;
  logic                row_neg_q, col_neg_q;
  logic                val_q;
  logic                res_read_q, res_read_d;

  logic                out_valid_q, out_valid_d;
  logic                out_read_q;
  logic [31:0]         out_gen_q;

  // memory port
  logic                mem_we;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [MAX_COLS-1:0] mem_wdata, mem_rdata;

  // datapath helpers
  logic                in_accept, out_free, out_load;
  logic                in_grid;
  logic [ColW-1:0]     col_sel;
  logic [MAX_COLS-1:0] col_mask, new_row, rule_row, cell_row;
  logic [ScW-1:0]      arr_idx, wr_idx;
  logic                arr_ok, wr_ok, step_last;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign out_load  = (state_q == lgge_pkg::ST_DONE) && out_free;

  // Position check for the latched read/write word
  assign in_grid = !row_neg_q && !col_neg_q
                && (CmpW'(row_q) < CmpW'(rows_q)) && (CmpW'(row_q) < CmpW'(MAX_ROWS))
                && (CmpW'(col_q) < CmpW'(cols_q)) && (CmpW'(col_q) < CmpW'(MAX_COLS));
  assign col_sel = ColW'(col_q);

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = CmpW'(c) < CmpW'(cols_q);
    end
  end

  // Step window: the read issued at sc-1 lands now (row sc-1); row sc-2 is
  // written. The arrival at sc == MAX_ROWS+1 is the dead row below the grid.
  assign arr_idx   = sc_q - ScW'(1);
  assign wr_idx    = sc_q - ScW'(2);
  assign arr_ok    = (CmpW'(arr_idx) < CmpW'(rows_q)) && (CmpW'(arr_idx) < CmpW'(MAX_ROWS));
  assign wr_ok     = CmpW'(wr_idx) < CmpW'(rows_q);
  assign new_row   = arr_ok ? (mem_rdata & col_mask) : '0;
  assign step_last = sc_q == ScW'(MAX_ROWS + 1);

  lgge_row_rule #(
    .COLS(MAX_COLS)
  ) u_rule (
    .above_i (prev_q),
    .center_i(cur_q),
    .below_i (new_row),
    .next_o  (rule_row)
  );

  // Read-modify-write row for a cell write
  always_comb begin
    cell_row = mem_rdata;
    cell_row[col_sel] = val_q;
  end

  lgge_grid_mem #(
    .AW(AW),
    .DW(MAX_COLS)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lgge_pkg::ST_CLEAR: begin
        if (clr_q == RowW'(MAX_ROWS - 1)) begin
          state_d = lgge_pkg::ST_IDLE;
        end
      end
      lgge_pkg::ST_IDLE: begin
        if (in_accept) begin
          unique case (lgge_pkg::cmd_e'(cmd_i))
            lgge_pkg::CMD_WRITE,
            lgge_pkg::CMD_READ: state_d = lgge_pkg::ST_CELL;
            lgge_pkg::CMD_STEP: state_d = lgge_pkg::ST_STEP;
            lgge_pkg::CMD_NOP:  state_d = lgge_pkg::ST_DONE;
          endcase
        end
      end
      lgge_pkg::ST_CELL: state_d = lgge_pkg::ST_DONE;
      lgge_pkg::ST_STEP: begin
        if (step_last) begin
          state_d = lgge_pkg::ST_DONE;
        end
      end
      lgge_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = lgge_pkg::ST_IDLE;
        end
      end
      default: state_d = lgge_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory port, counters, result
  always_comb begin
    in_stall_o  = state_q != lgge_pkg::ST_IDLE;
    mem_we      = 1'b0;
    mem_waddr   = {bank_q, RowW'(row_q)};
    mem_wdata   = cell_row;
    mem_raddr   = {bank_q, RowW'(row_i[6:0])};
    bank_d      = bank_q;
    gen_d       = gen_q;
    clr_d       = clr_q;
    sc_d        = sc_q;
    res_read_d  = res_read_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      lgge_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = {bank_q, clr_q};
        mem_wdata = '0;
        clr_d     = clr_q + RowW'(1);
      end
      lgge_pkg::ST_IDLE: begin
        // cell row is fetched at accept time
        sc_d       = '0;
        res_read_d = 1'b0;
      end
      lgge_pkg::ST_CELL: begin
        mem_we     = (cmd_q == lgge_pkg::CMD_WRITE) && in_grid;
        res_read_d = (cmd_q == lgge_pkg::CMD_READ) && in_grid && mem_rdata[col_sel];
      end
      lgge_pkg::ST_STEP: begin
        mem_raddr = {bank_q, RowW'(sc_q)};
        mem_we    = sc_q >= ScW'(2);
        mem_waddr = {~bank_q, RowW'(wr_idx)};
        mem_wdata = wr_ok ? (rule_row & col_mask) : '0;
        sc_d      = sc_q + ScW'(1);
        if (step_last) begin
          bank_d = ~bank_q;
          gen_d  = gen_q + 32'd1;
        end
      end
      lgge_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lgge_pkg::ST_CLEAR;
      bank_q      <= 1'b0;
      gen_q       <= '0;
      clr_q       <= '0;
      sc_q        <= '0;
      out_valid_q <= 1'b0;
      cols_q      <= lgge_pkg::DimReset;
      rows_q      <= lgge_pkg::DimReset;
    end else begin
      state_q     <= state_d;
      bank_q      <= bank_d;
      gen_q       <= gen_d;
      clr_q       <= clr_d;
      sc_q        <= sc_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_index_i == lgge_pkg::CfgColsIdx)) begin
        cols_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_index_i == lgge_pkg::CfgRowsIdx)) begin
        rows_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    res_read_q <= res_read_d;
    if (in_accept) begin
      cmd_q     <= lgge_pkg::cmd_e'(cmd_i);
      row_q     <= row_i[6:0];
      row_neg_q <= row_i[7];
      col_q     <= col_i[6:0];
      col_neg_q <= col_i[7];
      val_q     <= cell_value_i;
      prev_q    <= '0;
      cur_q     <= '0;
    end else if ((state_q == lgge_pkg::ST_STEP) && (sc_q != '0)) begin
      prev_q <= cur_q;
      cur_q  <= new_row;
    end
    if (out_load) begin
      out_read_q <= res_read_q;
      out_gen_q  <= gen_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign read_value_o       = out_read_q;
  assign generation_count_o = out_gen_q;

`ifndef NO_ASSERTIONS
  // A result only appears from the result stage
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == lgge_pkg::ST_DONE)
    else $error("result word raised outside the result stage");

  // The generation count only moves at the end of a step
  a_gen_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_q != $past(gen_q) |-> $past(state_q) == lgge_pkg::ST_STEP)
    else $error("generation count changed outside a step");

  // Bank flip goes with exactly one count increment
  a_bank_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bank_q != $past(bank_q) |-> gen_q == $past(gen_q) + 32'd1)
    else $error("bank flipped without a generation increment");

  // A step never writes the bank it is reading
  a_step_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lgge_pkg::ST_STEP) && mem_we |-> mem_waddr[AW-1] != bank_q)
    else $error("step wrote into the live bank");
`endif

endmodule

// ===== design/lgge_grid_mem.sv =====
// Row-wide grid memory: one write port, one read port, registered read data.
// No dependencies.
module lgge_grid_mem #(
  parameter int AW = 7,
  parameter int DW = 64
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/lgge_row_rule.sv =====
// Next-generation rule for one full row of cells from three neighboring rows.
// Depends on lgge_pkg (rule counts).
module lgge_row_rule #(
  parameter int COLS = 64
) (
  input  logic [COLS-1:0] above_i,
  input  logic [COLS-1:0] center_i,
  input  logic [COLS-1:0] below_i,
  output logic [COLS-1:0] next_o
);

  always_comb begin
    logic [COLS+1:0] up_p;
    logic [COLS+1:0] mid_p;
    logic [COLS+1:0] dn_p;
    logic [3:0]      n;
    // dead cell padding on both edges
    up_p  = {1'b0, above_i, 1'b0};
    mid_p = {1'b0, center_i, 1'b0};
    dn_p  = {1'b0, below_i, 1'b0};
    n     = '0;
    next_o = '0;
    for (int c = 0; c < COLS; c++) begin
      n = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2])
        + 4'(mid_p[c]) + 4'(mid_p[c+2])
        + 4'(dn_p[c]) + 4'(dn_p[c+1]) + 4'(dn_p[c+2]);
      next_o[c] = (n == lgge_pkg::BirthCount) ||
                  (mid_p[c+1] && (n == lgge_pkg::SurviveCount));
    end
  end

endmodule
